### sv/rv32ls_pkg.sv
package rv32ls_pkg;

	// Data memory geometry (word addressed, depth is a power of two)
	localparam int DATA_WORDS = 4096;
	localparam int ADDR_W     = $clog2(DATA_WORDS);

	// Register file and datapath widths
	localparam int XLEN    = 32;
	localparam int REGS    = 32;
	localparam int REG_W   = 5;
	localparam int MADDR_W = 12;

	// Clear sweep covers whichever store is deeper
	localparam int CLR_W     = (ADDR_W > REG_W) ? ADDR_W : REG_W;
	localparam int CLR_DEPTH = (DATA_WORDS > REGS) ? DATA_WORDS : REGS;

	localparam logic [XLEN-1:0] PC_START = 32'h0000_1000;

	// Major opcodes
	localparam logic [6:0] OPC_LOAD  = 7'h03;
	localparam logic [6:0] OPC_STORE = 7'h23;
	localparam logic [6:0] OPC_OPIMM = 7'h13;

	// Load funct3
	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;

	// Store funct3
	localparam logic [2:0] F3_SB = 3'd0;
	localparam logic [2:0] F3_SH = 3'd1;
	localparam logic [2:0] F3_SW = 3'd2;

	// OP-IMM funct3
	localparam logic [2:0] F3_ADDI  = 3'd0;
	localparam logic [2:0] F3_SLTI  = 3'd2;
	localparam logic [2:0] F3_SLTIU = 3'd3;
	localparam logic [2:0] F3_XORI  = 3'd4;
	localparam logic [2:0] F3_ORI   = 3'd6;
	localparam logic [2:0] F3_ANDI  = 3'd7;

	// Result status codes
	typedef logic [1:0] status_t;
	localparam status_t STAT_OK     = 2'd0;
	localparam status_t STAT_BAD_F3 = 2'd1;
	localparam status_t STAT_UNIMP  = 2'd2;

	// Sign-extend a 12-bit immediate
	function automatic logic [XLEN-1:0] sext12(input logic [11:0] v);
		return {{(XLEN-12){v[11]}}, v};
	endfunction

endpackage

### sv/rv32i_load_store_alu_imm_core.sv
// RV32I subset core (loads, stores, OP-IMM ALU) with a 32-entry register file and a
// word-addressed data memory of DATA_WORDS words. Each transfer on the instruction
// channel yields exactly one transfer on the result channel, in order. The core runs a
// three-stage pipeline: register file read at accept, decode/ALU/address and data
// memory access in the second stage, load extraction and register write-back in the
// third, then an output register. It takes one instruction per cycle while result_stall is
// low; an instruction whose rs1 or rs2 is the destination of the load directly ahead of it
// waits until that load writes back, since the load data leaves the memory read register
// only in the write-back stage. After reset the core sweeps zero through the data memory
// and register file, one entry per cycle, and holds instr_stall high until the sweep is
// done. Memory addresses wrap modulo DATA_WORDS.
module rv32i_load_store_alu_imm_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              instr_valid,
	output logic                              instr_stall,
	input  logic [rv32ls_pkg::XLEN-1:0]       instruction,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [rv32ls_pkg::XLEN-1:0]       instr_pc,
	output logic                              reg_written,
	output logic [rv32ls_pkg::REG_W-1:0]      dest_index,
	output logic [rv32ls_pkg::XLEN-1:0]       dest_value,
	output logic                              mem_written,
	output logic [rv32ls_pkg::MADDR_W-1:0]    mem_word_address,
	output logic [rv32ls_pkg::XLEN-1:0]       mem_value,
	output rv32ls_pkg::status_t               status
);
	import rv32ls_pkg::*;

	// Storage
	logic [XLEN-1:0] rf   [REGS];
	logic [XLEN-1:0] dmem [DATA_WORDS];

	// Control state
	logic             clr_busy_q;
	logic [CLR_W-1:0] clr_cnt_q;
	logic [XLEN-1:0]  pc_q;
	logic             valid_s1, valid_s2, valid_s3;

	// Stage 1 payload
	logic [XLEN-1:0] instr_s1, pc_s1, a_s1, b_s1;

	// Stage 2 payload
	logic [XLEN-1:0]    pc_s2, alu_s2, mval_s2, ld_word_s2;
	logic               wr_s2, load_s2, memw_s2;
	logic [REG_W-1:0]   rd_s2;
	logic [2:0]         f3_s2;
	logic [MADDR_W-1:0] maddr_s2;
	status_t            status_s2;

	// Output stage payload
	logic [XLEN-1:0]    pc_s3, dval_s3, mval_s3;
	logic               wr_s3, memw_s3;
	logic [REG_W-1:0]   rd_s3;
	logic [MADDR_W-1:0] maddr_s3;
	status_t            status_s3;

	// Handshake and pipeline enables
	logic accept, en3, en2, hazard, mv12;

	// Stage 1 decode fields
	logic [6:0]       opc_s1;
	logic [2:0]       f3_s1;
	logic [REG_W-1:0] rd_s1, rs1_s1, rs2_s1, rs1_in, rs2_in;
	logic [XLEN-1:0]  src_a, src_b, imm_i, imm_s, addr_sum;
	logic [ADDR_W-1:0] addr_c;

	// Stage 1 results
	logic               wr_c, ld_c, st_c;
	logic [XLEN-1:0]    alu_c, mval_c;
	logic [MADDR_W-1:0] maddr_c;
	status_t            status_c;

	// Stage 2 results
	logic [XLEN-1:0] ld_val, dval_s2;

	// Write ports
	logic              rf_we;
	logic [REG_W-1:0]  rf_widx;
	logic [XLEN-1:0]   rf_wdata;
	logic              dm_we;
	logic [ADDR_W-1:0] dm_waddr;
	logic [XLEN-1:0]   dm_wdata;

	// Advance stages toward the output register
	assign en3         = !valid_s3 || !result_stall;
	assign en2         = !valid_s2 || en3;
	assign hazard      = valid_s1 && valid_s2 && wr_s2 && load_s2 &&
		((rd_s2 == rs1_s1) || (rd_s2 == rs2_s1));
	assign mv12        = valid_s1 && en2 && !hazard;
	assign instr_stall = clr_busy_q || (valid_s1 && !mv12);
	assign accept      = instr_valid && !instr_stall;

	// Decode fields
	assign rs1_in = instruction[19:15];
	assign rs2_in = instruction[24:20];
	assign opc_s1 = instr_s1[6:0];
	assign rd_s1  = instr_s1[11:7];
	assign f3_s1  = instr_s1[14:12];
	assign rs1_s1 = instr_s1[19:15];
	assign rs2_s1 = instr_s1[24:20];
	assign imm_i  = sext12(instr_s1[31:20]);
	assign imm_s  = sext12({instr_s1[31:25], instr_s1[11:7]});

	// Forward an ALU result still waiting in stage 2
	always_comb begin
		src_a = a_s1;
		src_b = b_s1;
		if (valid_s2 && wr_s2 && !load_s2) begin
			if (rd_s2 == rs1_s1)
				src_a = alu_s2;
			if (rd_s2 == rs2_s1)
				src_b = alu_s2;
		end
	end

	// Word address, wrapped to the memory depth
	assign addr_sum = src_a + ((opc_s1 == OPC_STORE) ? imm_s : imm_i);
	assign addr_c   = addr_sum[ADDR_W-1:0];

	// Execute: status, ALU, store data
	always_comb begin
		wr_c     = 1'b0;
		ld_c     = 1'b0;
		st_c     = 1'b0;
		alu_c    = '0;
		mval_c   = '0;
		status_c = STAT_OK;
		unique case (opc_s1)
			OPC_LOAD: begin
				unique case (f3_s1)
					F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU: begin
						ld_c = 1'b1;
						wr_c = 1'b1;
					end
					default: status_c = STAT_BAD_F3;
				endcase
			end
			OPC_STORE: begin
				unique case (f3_s1)
					F3_SB: begin
						st_c   = 1'b1;
						mval_c = {{(XLEN-8){1'b0}}, src_b[7:0]};
					end
					F3_SH: begin
						st_c   = 1'b1;
						mval_c = {{(XLEN-16){1'b0}}, src_b[15:0]};
					end
					F3_SW: begin
						st_c   = 1'b1;
						mval_c = src_b;
					end
					default: status_c = STAT_BAD_F3;
				endcase
			end
			OPC_OPIMM: begin
				wr_c = 1'b1;
				unique case (f3_s1)
					F3_ADDI:  alu_c = src_a + imm_i;
					F3_SLTI:  alu_c = {{(XLEN-1){1'b0}}, ($signed(src_a) < $signed(imm_i))};
					F3_SLTIU: alu_c = {{(XLEN-1){1'b0}}, (src_a < imm_i)};
					F3_XORI:  alu_c = src_a ^ imm_i;
					F3_ORI:   alu_c = src_a | imm_i;
					F3_ANDI:  alu_c = src_a & imm_i;
					default: begin
						wr_c     = 1'b0;
						status_c = STAT_UNIMP;
					end
				endcase
			end
			default: status_c = STAT_UNIMP;
		endcase
		if (rd_s1 == '0)
			wr_c = 1'b0;
	end

	assign maddr_c = (ld_c || st_c) ? MADDR_W'(32'(addr_c)) : '0;

	// Extract load data
	always_comb begin
		unique case (f3_s2)
			F3_LB:   ld_val = {{(XLEN-8){ld_word_s2[7]}}, ld_word_s2[7:0]};
			F3_LH:   ld_val = {{(XLEN-16){ld_word_s2[15]}}, ld_word_s2[15:0]};
			F3_LBU:  ld_val = {{(XLEN-8){1'b0}}, ld_word_s2[7:0]};
			F3_LHU:  ld_val = {{(XLEN-16){1'b0}}, ld_word_s2[15:0]};
			default: ld_val = ld_word_s2;
		endcase
	end

	assign dval_s2 = load_s2 ? ld_val : alu_s2;

	// Register file write port: clear sweep or write-back on retire
	always_comb begin
		if (clr_busy_q) begin
			rf_we    = 32'(clr_cnt_q) < REGS;
			rf_widx  = clr_cnt_q[REG_W-1:0];
			rf_wdata = '0;
		end else begin
			rf_we    = valid_s2 && en3 && wr_s2;
			rf_widx  = rd_s2;
			rf_wdata = dval_s2;
		end
	end

	// Data memory write port: clear sweep or store
	always_comb begin
		if (clr_busy_q) begin
			dm_we    = 32'(clr_cnt_q) < DATA_WORDS;
			dm_waddr = clr_cnt_q[ADDR_W-1:0];
			dm_wdata = '0;
		end else begin
			dm_we    = mv12 && st_c;
			dm_waddr = addr_c;
			dm_wdata = mval_c;
		end
	end

	// Register file: write, read at accept, snoop later writes into held operands
	always_ff @(posedge clk) begin
		if (rf_we)
			rf[rf_widx] <= rf_wdata;
		if (accept) begin
			a_s1 <= (rf_we && rf_widx == rs1_in) ? rf_wdata : rf[rs1_in];
			b_s1 <= (rf_we && rf_widx == rs2_in) ? rf_wdata : rf[rs2_in];
		end else begin
			if (rf_we && rf_widx == rs1_s1)
				a_s1 <= rf_wdata;
			if (rf_we && rf_widx == rs2_s1)
				b_s1 <= rf_wdata;
		end
	end

	// Data memory: write, registered read on transfer into stage 2
	always_ff @(posedge clk) begin
		if (dm_we)
			dmem[dm_waddr] <= dm_wdata;
		if (mv12)
			ld_word_s2 <= dmem[addr_c];
	end

	// Control: clear sweep, pc, stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			pc_q       <= PC_START;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == CLR_W'(CLR_DEPTH - 1))
					clr_busy_q <= 1'b0;
			end
			if (accept)
				pc_q <= pc_q + 1'b1;
			if (!valid_s1 || mv12)
				valid_s1 <= accept;
			if (en2)
				valid_s2 <= mv12;
			if (en3)
				valid_s3 <= valid_s2;
		end
	end

	// Stage payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instruction;
			pc_s1    <= pc_q;
		end
		if (mv12) begin
			pc_s2     <= pc_s1;
			wr_s2     <= wr_c;
			rd_s2     <= wr_c ? rd_s1 : '0;
			load_s2   <= ld_c;
			f3_s2     <= f3_s1;
			alu_s2    <= alu_c;
			memw_s2   <= st_c;
			maddr_s2  <= maddr_c;
			mval_s2   <= mval_c;
			status_s2 <= status_c;
		end
		if (valid_s2 && en3) begin
			pc_s3     <= pc_s2;
			wr_s3     <= wr_s2;
			rd_s3     <= rd_s2;
			dval_s3   <= wr_s2 ? dval_s2 : '0;
			memw_s3   <= memw_s2;
			maddr_s3  <= maddr_s2;
			mval_s3   <= mval_s2;
			status_s3 <= status_s2;
		end
	end

	// Drive result ports
	assign result_valid     = valid_s3;
	assign instr_pc         = pc_s3;
	assign reg_written      = wr_s3;
	assign dest_index       = rd_s3;
	assign dest_value       = dval_s3;
	assign mem_written      = memw_s3;
	assign mem_word_address = maddr_s3;
	assign mem_value        = mval_s3;
	assign status           = status_s3;

endmodule

### sv/rv32ls_chk.sv
module rv32ls_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              result_valid,
	input logic                              result_stall,
	input logic [rv32ls_pkg::XLEN-1:0]       instr_pc,
	input logic                              reg_written,
	input logic [rv32ls_pkg::REG_W-1:0]      dest_index,
	input logic [rv32ls_pkg::XLEN-1:0]       dest_value,
	input logic                              mem_written,
	input logic [rv32ls_pkg::MADDR_W-1:0]    mem_word_address,
	input logic [rv32ls_pkg::XLEN-1:0]       mem_value,
	input rv32ls_pkg::status_t               status
);
	import rv32ls_pkg::*;

	logic            seen_q;
	logic [XLEN-1:0] last_pc_q;

	// Track the pc of the last result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			last_pc_q <= '0;
		end else if (result_valid && !result_stall) begin
			seen_q    <= 1'b1;
			last_pc_q <= instr_pc;
		end
	end

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(instr_pc) && $stable(status))
		else $error("stalled result changed");

	// Results come out in order, one per instruction
	a_pc_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && seen_q |-> instr_pc == last_pc_q + 1'b1)
		else $error("result pc out of sequence");

	// A failed instruction writes nothing and reports no address
	a_fail_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != STAT_OK |->
			!reg_written && !mem_written && mem_word_address == '0)
		else $error("failed instruction has side effects");

	// Register write fields are zero unless a nonzero register was written
	a_dest_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (reg_written && dest_index != '0) ||
			(!reg_written && dest_index == '0 && dest_value == '0))
		else $error("destination fields inconsistent");

	// Store and register write never occur together; stores carry zero when absent
	a_mem_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(mem_written && reg_written) &&
			(mem_written || mem_value == '0))
		else $error("memory fields inconsistent");

endmodule

bind rv32i_load_store_alu_imm_core rv32ls_chk u_rv32ls_chk (.*);

### tb/rv32i_core_checker.sv
`timescale 1ns / 100ps
module rv32i_core_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           instr_valid,
	input  logic                           instr_stall,
	input  logic [rv32ls_pkg::XLEN-1:0]    instruction,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  logic [rv32ls_pkg::XLEN-1:0]    instr_pc,
	input  logic                           reg_written,
	input  logic [rv32ls_pkg::REG_W-1:0]   dest_index,
	input  logic [rv32ls_pkg::XLEN-1:0]    dest_value,
	input  logic                           mem_written,
	input  logic [rv32ls_pkg::MADDR_W-1:0] mem_word_address,
	input  logic [rv32ls_pkg::XLEN-1:0]    mem_value,
	input  rv32ls_pkg::status_t            status,
	output int                             errors,
	output int                             pending
);
	import rv32ls_pkg::*;

	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic [XLEN-1:0]    pc;
		logic               rwr;
		logic [REG_W-1:0]   rd;
		logic [XLEN-1:0]    rval;
		logic               mwr;
		logic [MADDR_W-1:0] maddr;
		logic [XLEN-1:0]    mval;
		status_t            st;
	} core_result_t;

	core_result_t    expected_q [$];
	logic [XLEN-1:0] arch_regs [REGS];
	logic [XLEN-1:0] arch_mem [DATA_WORDS];
	logic [XLEN-1:0] arch_pc;
	int              err_count = 0;
	int              pend_count = 0;

	assign errors  = err_count;
	assign pending = pend_count;

	// Execute one instruction against the architectural copy and return its result
	function automatic core_result_t execute_instr(input logic [XLEN-1:0] w);
		core_result_t      r;
		logic [6:0]        opc;
		logic [2:0]        f3;
		logic [REG_W-1:0]  rd;
		logic [XLEN-1:0]   a;
		logic [XLEN-1:0]   b;
		logic [XLEN-1:0]   imm;
		logic [XLEN-1:0]   mword;
		logic [XLEN-1:0]   wval;
		logic [XLEN-1:0]   sval;
		logic [ADDR_W-1:0] ad;
		logic              wr;
		opc  = w[6:0];
		rd   = w[11:7];
		f3   = w[14:12];
		a    = arch_regs[w[19:15]];
		b    = arch_regs[w[24:20]];
		r    = '0;
		r.pc = arch_pc;
		r.st = STAT_OK;
		wr   = 1'b0;
		wval = '0;
		arch_pc = arch_pc + 1;
		case (opc)
			OPC_LOAD: begin
				imm   = {{20{w[31]}}, w[31:20]};
				ad    = ADDR_W'(a + imm);
				mword = arch_mem[ad];
				wr    = 1'b1;
				r.maddr = MADDR_W'(ad);
				case (f3)
					F3_LB:  wval = {{24{mword[7]}}, mword[7:0]};
					F3_LH:  wval = {{16{mword[15]}}, mword[15:0]};
					F3_LW:  wval = mword;
					F3_LBU: wval = {24'd0, mword[7:0]};
					F3_LHU: wval = {16'd0, mword[15:0]};
					default: begin
						wr      = 1'b0;
						r.maddr = '0;
						r.st    = STAT_BAD_F3;
					end
				endcase
			end
			OPC_STORE: begin
				imm = {{20{w[31]}}, w[31:25], w[11:7]};
				ad  = ADDR_W'(a + imm);
				case (f3)
					F3_SB:   sval = {24'd0, b[7:0]};
					F3_SH:   sval = {16'd0, b[15:0]};
					F3_SW:   sval = b;
					default: sval = '0;
				endcase
				if (f3 == F3_SB || f3 == F3_SH || f3 == F3_SW) begin
					arch_mem[ad] = sval;
					r.mwr   = 1'b1;
					r.maddr = MADDR_W'(ad);
					r.mval  = sval;
				end else begin
					r.st = STAT_BAD_F3;
				end
			end
			OPC_OPIMM: begin
				imm = {{20{w[31]}}, w[31:20]};
				wr  = 1'b1;
				case (f3)
					F3_ADDI:  wval = a + imm;
					F3_SLTI:  wval = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
					F3_SLTIU: wval = (a < imm) ? 32'd1 : 32'd0;
					F3_XORI:  wval = a ^ imm;
					F3_ORI:   wval = a | imm;
					F3_ANDI:  wval = a & imm;
					default: begin
						wr   = 1'b0;
						r.st = STAT_UNIMP;
					end
				endcase
			end
			default: r.st = STAT_UNIMP;
		endcase
		// x0 is never written
		if (wr && rd != '0) begin
			arch_regs[rd] = wval;
			r.rwr  = 1'b1;
			r.rd   = rd;
			r.rval = wval;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [XLEN-1:0] want,
			input logic [XLEN-1:0] got, input logic [XLEN-1:0] pc);
		if (want !== got) begin
			if (err_count < MAX_REPORTS)
				$display("%0t: pc %h %s expected %h actual %h", $time, pc, name, want, got);
			err_count++;
		end
	endtask

	// Predict on each instruction transfer, compare on each result transfer
	always @(posedge clk or negedge arst_n) begin : track_proc
		core_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < REGS; i++)
				arch_regs[i] = '0;
			for (int i = 0; i < DATA_WORDS; i++)
				arch_mem[i] = '0;
			arch_pc = PC_START;
			expected_q.delete();
			pend_count = 0;
		end else begin
			if (instr_valid && !instr_stall)
				expected_q.push_back(execute_instr(instruction));
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					if (err_count < MAX_REPORTS)
						$display("%0t: result transfer with nothing expected, pc %h",
							$time, instr_pc);
					err_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("instr_pc", want.pc, instr_pc, want.pc);
					check_field("reg_written", XLEN'(want.rwr), XLEN'(reg_written),
						want.pc);
					check_field("dest_index", XLEN'(want.rd), XLEN'(dest_index), want.pc);
					check_field("dest_value", want.rval, dest_value, want.pc);
					check_field("mem_written", XLEN'(want.mwr), XLEN'(mem_written),
						want.pc);
					check_field("mem_word_address", XLEN'(want.maddr),
						XLEN'(mem_word_address), want.pc);
					check_field("mem_value", want.mval, mem_value, want.pc);
					check_field("status", XLEN'(want.st), XLEN'(status), want.pc);
				end
			end
			pend_count = expected_q.size();
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
	import rv32ls_pkg::*;

	localparam int RANDOM_ITEMS = 1450;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_PCT     = 27;

	// Encodings the package does not name
	localparam logic [2:0] F3_LD_BAD = 3'd3;
	localparam logic [2:0] F3_ST_BAD = 3'd7;
	localparam logic [2:0] F3_SLLI   = 3'd1;
	localparam logic [2:0] F3_SRXI   = 3'd5;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_FENCE  = 7'h0f;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;

	logic                 clk;
	logic                 arst_n;
	logic                 instr_valid;
	logic                 instr_stall;
	logic [XLEN-1:0]      instruction;
	logic                 result_valid;
	logic                 result_stall;
	logic [XLEN-1:0]      instr_pc;
	logic                 reg_written;
	logic [REG_W-1:0]     dest_index;
	logic [XLEN-1:0]      dest_value;
	logic                 mem_written;
	logic [MADDR_W-1:0]   mem_word_address;
	logic [XLEN-1:0]      mem_value;
	status_t              status;
	int                   errors;
	int                   pending;
	bit                   no_idle;
	bit                   hold_req;
	bit                   hold_done;
	int                   hold_left;

	rv32i_load_store_alu_imm_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.instr_valid      (instr_valid),
		.instr_stall      (instr_stall),
		.instruction      (instruction),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.instr_pc         (instr_pc),
		.reg_written      (reg_written),
		.dest_index       (dest_index),
		.dest_value       (dest_value),
		.mem_written      (mem_written),
		.mem_word_address (mem_word_address),
		.mem_value        (mem_value),
		.status           (status)
	);

	rv32i_core_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.instr_valid      (instr_valid),
		.instr_stall      (instr_stall),
		.instruction      (instruction),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.instr_pc         (instr_pc),
		.reg_written      (reg_written),
		.dest_index       (dest_index),
		.dest_value       (dest_value),
		.mem_written      (mem_written),
		.mem_word_address (mem_word_address),
		.mem_value        (mem_value),
		.status           (status),
		.errors           (errors),
		.pending          (pending)
	);

	function automatic logic [XLEN-1:0] enc_i(input logic [6:0] opc, input logic [2:0] f3,
			input logic [4:0] rd, input logic [4:0] rs1, input logic [11:0] imm);
		return {imm, rs1, f3, rd, opc};
	endfunction

	function automatic logic [XLEN-1:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
			input logic [4:0] rs2, input logic [11:0] imm);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
	endfunction

	// Favor the low registers so results feed later instructions
	function automatic logic [4:0] pick_reg();
		if ($urandom_range(0, 3) == 0)
			return 5'($urandom_range(0, 31));
		return 5'($urandom_range(0, 7));
	endfunction

	// Offsets cluster near both ends and the middle of the memory so stores and loads meet
	function automatic logic [11:0] pick_offset();
		case ($urandom_range(0, 3))
			0:       return 12'($urandom);
			1:       return 12'($urandom_range(0, 15));
			2:       return 12'(4096 - $urandom_range(1, 16));
			default: return 12'($urandom_range(2040, 2055));
		endcase
	endfunction

	function automatic logic [XLEN-1:0] rand_instr();
		logic [XLEN-1:0] w;
		logic [11:0]     imm;
		logic [4:0]      base;
		logic [2:0]      f3;
		logic [6:0]      opc;
		int              k;
		w    = $urandom;
		k    = $urandom_range(0, 99);
		base = $urandom_range(0, 1) ? 5'd0 : pick_reg();
		imm  = pick_offset();
		if (k < 25) begin
			f3 = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom);
			if (f3 == F3_LD_BAD && $urandom_range(0, 3) != 0)
				f3 = F3_LHU;
			return enc_i(OPC_LOAD, f3, pick_reg(), base, imm);
		end else if (k < 45) begin
			f3 = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 2)) : 3'($urandom);
			return enc_s(f3, base, pick_reg(), imm);
		end else if (k < 80) begin
			if ($urandom_range(0, 1) == 0)
				imm = 12'($urandom);
			return enc_i(OPC_OPIMM, 3'($urandom), pick_reg(), pick_reg(), imm);
		end else if (k < 90) begin
			case ($urandom_range(0, 7))
				0:       opc = OPC_OP;
				1:       opc = OPC_BRANCH;
				2:       opc = OPC_JAL;
				3:       opc = OPC_JALR;
				4:       opc = OPC_FENCE;
				5:       opc = OPC_SYSTEM;
				6:       opc = OPC_LUI;
				default: opc = OPC_AUIPC;
			endcase
			return {w[31:7], opc};
		end
		return w;
	endfunction

	// Offer one instruction, with random idle cycles ahead, and hold it until the transfer
	task automatic send(input logic [XLEN-1:0] word);
		bit stalled;
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			instr_valid <= 1'b0;
			@(posedge clk);
		end
		instr_valid <= 1'b1;
		instruction <= word;
		do begin
			@(negedge clk);
			stalled = instr_stall;
			@(posedge clk);
		end while (stalled);
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("rv32i_load_store_alu_imm_core verification failed");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		result_stall <= 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		logic [XLEN-1:0] directed [$];
		arst_n      <= 1'b0;
		instr_valid <= 1'b0;
		instruction <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Immediate extremes and every OP-IMM operation
		directed.push_back(enc_i(OPC_OPIMM, F3_ADDI, 5'd1, 5'd0, 12'hfff));
		directed.push_back(enc_i(OPC_OPIMM, F3_ADDI, 5'd2, 5'd0, 12'h7ff));
		directed.push_back(enc_i(OPC_OPIMM, F3_ADDI, 5'd3, 5'd0, 12'h800));
		directed.push_back(enc_i(OPC_OPIMM, F3_SLTI, 5'd4, 5'd1, 12'h000));
		directed.push_back(enc_i(OPC_OPIMM, F3_SLTIU, 5'd5, 5'd2, 12'hfff));
		directed.push_back(enc_i(OPC_OPIMM, F3_XORI, 5'd6, 5'd1, 12'h555));
		directed.push_back(enc_i(OPC_OPIMM, F3_ORI, 5'd7, 5'd3, 12'h0ff));
		directed.push_back(enc_i(OPC_OPIMM, F3_ANDI, 5'd8, 5'd1, 12'h800));
		// Write to x0 is dropped
		directed.push_back(enc_i(OPC_OPIMM, F3_ADDI, 5'd0, 5'd1, 12'h005));
		// Stores, two with negative addresses that wrap to the top of memory
		directed.push_back(enc_s(F3_SW, 5'd3, 5'd1, 12'h7ff));
		directed.push_back(enc_s(F3_SH, 5'd0, 5'd6, 12'hfff));
		directed.push_back(enc_s(F3_SB, 5'd2, 5'd1, 12'h000));
		// Loads; the first one feeds the next instruction directly
		directed.push_back(enc_i(OPC_LOAD, F3_LW, 5'd9, 5'd3, 12'h7ff));
		directed.push_back(enc_i(OPC_OPIMM, F3_ADDI, 5'd11, 5'd9, 12'h001));
		directed.push_back(enc_i(OPC_LOAD, F3_LB, 5'd10, 5'd0, 12'hfff));
		directed.push_back(enc_i(OPC_LOAD, F3_LH, 5'd12, 5'd0, 12'hfff));
		directed.push_back(enc_i(OPC_LOAD, F3_LBU, 5'd13, 5'd2, 12'h000));
		directed.push_back(enc_i(OPC_LOAD, F3_LHU, 5'd14, 5'd0, 12'hfff));
		// Unknown funct3, shift immediates, empty and unknown opcodes
		directed.push_back(enc_i(OPC_LOAD, F3_LD_BAD, 5'd15, 5'd0, 12'h000));
		directed.push_back(enc_s(F3_ST_BAD, 5'd0, 5'd1, 12'h004));
		directed.push_back(enc_i(OPC_OPIMM, F3_SLLI, 5'd16, 5'd1, 12'h003));
		directed.push_back(enc_i(OPC_OPIMM, F3_SRXI, 5'd17, 5'd1, 12'h405));
		directed.push_back(enc_i(OPC_OP, F3_ADDI, 5'd18, 5'd1, 12'h002));
		directed.push_back(enc_i(OPC_BRANCH, F3_ADDI, 5'd0, 5'd1, 12'h010));
		directed.push_back(enc_i(OPC_SYSTEM, F3_ADDI, 5'd0, 5'd0, 12'h000));
		directed.push_back(32'hffff_ffff);
		foreach (directed[i])
			send(directed[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Hold the result side off so the pipeline backs up into the input
			if (n == 200)
				hold_req = 1'b1;
			no_idle = (n >= 700 && n < 900);
			send(rand_instr());
		end
		instr_valid <= 1'b0;

		// Drain, then allow for stray results
		do @(negedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("rv32i_load_store_alu_imm_core verification clean");
		else
			$display("rv32i_load_store_alu_imm_core verification failed");
		$finish;
	end

endmodule

### rv32i_load_store_alu_imm_core.f
sv/rv32ls_pkg.sv
sv/rv32i_load_store_alu_imm_core.sv
sv/rv32ls_chk.sv
tb/rv32i_core_checker.sv
tb/tb_top.sv
